[design/fpa_pkg.sv]
// Shared types, constants and helper functions for the fixed-point ALU.
// No dependencies; used by fixed_point_alu.
`default_nettype none

package fpa_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int NUM_W      = 32 + FRAC_BITS;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int QW         = DIV_STAGES * DIV_STEPS;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_CMP = 4'd4,
    OP_MIN = 4'd5, OP_MAX = 4'd6, OP_INC = 4'd7, OP_DEC = 4'd8, OP_TOINT = 4'd9
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;

  typedef struct packed {
    logic [3:0]         op;
    logic               less;
    logic               eq;
    logic               gt;
    logic               neg;
    logic               bzero;
    logic signed [31:0] res;
    logic [1:0]         st;
    logic [31:0]        ma;
    logic [31:0]        mb;
    logic [63:0]        prod;
  } pipe_t;

  typedef struct packed {
    logic [QW-1:0] num;
    logic [QW-1:0] quo;
    logic [31:0]   rem;
  } div_t;

  typedef struct packed {
    logic signed [31:0] res;
    logic [1:0]         st;
  } sat_t;

  // Several restoring division steps; numerator bits leave from the top.
  function automatic div_t div_step(div_t cur, logic [31:0] d);
    div_t        w;
    logic [32:0] t;
    w = cur;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {w.rem, w.num[QW-1]};
      w.num = {w.num[QW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        w.quo = {w.quo[QW-2:0], 1'b1};
      end else begin
        w.quo = {w.quo[QW-2:0], 1'b0};
      end
      w.rem = t[31:0];
    end
    return w;
  endfunction

  // Applies the sign to a magnitude and saturates to 32 bits.
  function automatic sat_t sat_mag(logic [63:0] m, logic neg);
    sat_t s;
    s.st = ST_OK;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        s.res = MIN_VAL;
        s.st  = ST_OVF;
      end else begin
        s.res = 32'(0 - m[31:0]);
      end
    end else begin
      if (m > 64'h7FFF_FFFF) begin
        s.res = MAX_VAL;
        s.st  = ST_OVF;
      end else begin
        s.res = m[31:0];
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[design/fixed_point_alu.sv]
// Each beat passes through the stage 0 register, the DIV_STAGES divider stages and the output register.
// Throughput: one beat per cycle while the result is not stalled; the divider is cut into stages of four quotient bits.
// A stalled result freezes the whole pipeline in place; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
// Depends on fpa_pkg for the operation codes, status codes and arithmetic helpers.
`default_nettype none

module fixed_point_alu (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output                     logic in_stall,
  input  wire                logic [3:0] in_operation,
  input  wire                logic signed [31:0] in_operand_a,
  input  wire                logic signed [31:0] in_operand_b,
  output                     logic out_valid,
  input  wire                logic out_stall,
  output                     logic signed [31:0] out_result_value,
  output                     logic out_a_less,
  output                     logic out_a_equal,
  output                     logic out_a_greater,
  output                     logic [1:0] out_status
);
  import fpa_pkg::*;

  // The pipeline advances as one whenever the output register can move.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 0 computes the simple operations, flags, magnitudes and signs.
  pipe_t p0_nxt;
  div_t  d0_nxt;
  logic signed [32:0] sum;
  logic signed [32:0] rhs;

  always_comb begin
    p0_nxt       = '0;
    p0_nxt.op    = in_operation;
    p0_nxt.less  = in_operand_a < in_operand_b;
    p0_nxt.eq    = in_operand_a == in_operand_b;
    p0_nxt.gt    = in_operand_a > in_operand_b;
    p0_nxt.neg   = in_operand_a[31] ^ in_operand_b[31];
    p0_nxt.bzero = in_operand_b == 32'sd0;
    p0_nxt.ma    = in_operand_a[31] ? 32'(0 - in_operand_a) : in_operand_a;
    p0_nxt.mb    = in_operand_b[31] ? 32'(0 - in_operand_b) : in_operand_b;
    p0_nxt.st    = ST_OK;
    p0_nxt.res   = '0;
    case (in_operation)
      OP_ADD:  rhs = {in_operand_b[31], in_operand_b};
      OP_SUB:  rhs = -{in_operand_b[31], in_operand_b};
      OP_INC:  rhs = 33'sd1;
      OP_DEC:  rhs = -33'sd1;
      default: rhs = '0;
    endcase
    sum = {in_operand_a[31], in_operand_a} + rhs;
    case (in_operation)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (sum[32] != sum[31]) begin
          p0_nxt.res = sum[32] ? MIN_VAL : MAX_VAL;
          p0_nxt.st  = ST_OVF;
        end else begin
          p0_nxt.res = sum[31:0];
        end
      end
      OP_MIN:   p0_nxt.res = p0_nxt.less ? in_operand_a : in_operand_b;
      OP_MAX:   p0_nxt.res = p0_nxt.gt ? in_operand_a : in_operand_b;
      OP_TOINT: p0_nxt.res = in_operand_a >>> FRAC_BITS;
      default:  p0_nxt.res = '0;
    endcase
    d0_nxt     = '0;
    d0_nxt.num = QW'({p0_nxt.ma, {FRAC_BITS{1'b0}}});
  end

  // Stages 0..DIV_STAGES; stage g > 0 retires four quotient bits.
  pipe_t p_r [DIV_STAGES+1];
  div_t  d_r [DIV_STAGES+1];
  logic  v_r [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      p_r[0] <= p0_nxt;
      d_r[0] <= d0_nxt;
    end
  end

  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
    pipe_t p_nxt;
    always_comb begin
      p_nxt = p_r[g-1];
      // The product is formed once, in the first divider stage.
      if (g == 1) begin
        p_nxt.prod = 64'(p_r[g-1].ma) * 64'(p_r[g-1].mb);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_r[g-1];
      end
      if (en) begin
        p_r[g] <= p_nxt;
        d_r[g] <= div_step(d_r[g-1], p_r[g-1].mb);
      end
    end
  end

  // Final stage: rounding half away from zero for multiply and divide, then saturation.
  pipe_t       pl;
  div_t        dl;
  logic [63:0] mul_mag;
  logic [QW:0] div_mag;
  sat_t        mul_s;
  sat_t        div_s;
  logic signed [31:0] res_nxt;
  logic [1:0]  st_nxt;

  always_comb begin
    pl      = p_r[DIV_STAGES];
    dl      = d_r[DIV_STAGES];
    mul_mag = (pl.prod + 64'((65'd1 << FRAC_BITS) >> 1)) >> FRAC_BITS;
    div_mag = {1'b0, dl.quo} + (QW+1)'({dl.rem, 1'b0} >= {1'b0, pl.mb});
    mul_s   = sat_mag(mul_mag, pl.neg);
    div_s   = sat_mag(64'(div_mag), pl.neg);
    res_nxt = pl.res;
    st_nxt  = pl.st;
    case (pl.op)
      OP_MUL: begin
        res_nxt = mul_s.res;
        st_nxt  = mul_s.st;
      end
      OP_DIV: begin
        if (pl.bzero) begin
          res_nxt = '0;
          st_nxt  = ST_DIVZ;
        end else begin
          res_nxt = div_s.res;
          st_nxt  = div_s.st;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_r[DIV_STAGES];
    end
    if (en) begin
      out_result_value <= res_nxt;
      out_status       <= st_nxt;
      out_a_less       <= pl.less;
      out_a_equal      <= pl.eq;
      out_a_greater    <= pl.gt;
    end
  end

  // Exactly one compare flag is set on every result.
  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_a_less, out_a_equal, out_a_greater}))
    else $error("compare flags not one-hot");

  // Division by zero always returns zero.
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DIVZ |-> out_result_value == 32'sd0)
    else $error("division by zero with nonzero result");

  // A saturated result sits on one of the bounds.
  a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVF |->
      out_result_value == MAX_VAL || out_result_value == MIN_VAL)
    else $error("overflow status without saturated value");

  // Status never takes the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("illegal status code");

endmodule

`default_nettype wire

[dv/fixed_point_alu_test.sv]
// Self-checking testbench for the fixed-point ALU: directed table, then random beats.
// Depends on fpa_pkg and fixed_point_alu; nothing else is needed to run it.
`timescale 1ns / 1ps

module fixed_point_alu_test;
  import fpa_pkg::*;

  // One result beat as the block reports it.
  typedef struct {
    logic signed [31:0] value;
    logic               less;
    logic               equal;
    logic               greater;
    logic [1:0]         status;
  } alu_result_t;

  // One row of the directed table. When has_known is set, the typed-in
  // result is compared against the predictor so that both must agree.
  typedef struct {
    logic [3:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    bit                 has_known;
    logic signed [31:0] known_value;
    logic [1:0]         known_status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_operation = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_result_value;
  logic out_a_less, out_a_equal, out_a_greater;
  logic [1:0] out_status;

  alu_result_t pending_results[$];
  int mismatch_count = 0;
  int beats_sent = 0;
  bit long_hold = 1'b0;
  bit stim_done = 1'b0;

  fixed_point_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_a_less(out_a_less),
    .out_a_equal(out_a_equal), .out_a_greater(out_a_greater),
    .out_status(out_status)
  );

  always #5 clk = ~clk;

  // Saturates a wide signed value to 32 bits and flags overflow.
  function automatic void clamp_word(input logic signed [65:0] v,
                                     inout alu_result_t r);
    if (v > 66'sd2147483647) begin
      r.value  = MAX_VAL;
      r.status = ST_OVF;
    end else if (v < -66'sd2147483648) begin
      r.value  = MIN_VAL;
      r.status = ST_OVF;
    end else begin
      r.value = v[31:0];
    end
  endfunction

  // Computes what the ALU must return for one input beat, with exact
  // wide integer arithmetic and rounding half away from zero.
  function automatic alu_result_t alu_predict(logic [3:0] op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [65:0] wa, wb, signed_mag;
    logic [65:0] ma, mb, m, num, q;
    bit neg;
    wa = a;
    wb = b;
    ma = (wa < 0) ? -wa : wa;
    mb = (wb < 0) ? -wb : wb;
    neg = (a < 0) != (b < 0);
    r.value   = '0;
    r.status  = ST_OK;
    r.less    = a < b;
    r.equal   = a == b;
    r.greater = a > b;
    case (op)
      OP_ADD: clamp_word(wa + wb, r);
      OP_SUB: clamp_word(wa - wb, r);
      OP_MUL: begin
        m = (ma * mb + ((66'd1 << FRAC_BITS) >> 1)) >> FRAC_BITS;
        signed_mag = m;
        clamp_word(neg ? -signed_mag : signed_mag, r);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.status = ST_DIVZ;
        end else begin
          num = ma << FRAC_BITS;
          q = (2 * num + mb) / (2 * mb);
          signed_mag = q;
          clamp_word(neg ? -signed_mag : signed_mag, r);
        end
      end
      OP_CMP: r.value = '0;
      OP_MIN: r.value = (a < b) ? a : b;
      OP_MAX: r.value = (a > b) ? a : b;
      OP_INC: clamp_word(wa + 1, r);
      OP_DEC: clamp_word(wa - 1, r);
      OP_TOINT: r.value = a >>> FRAC_BITS;
      default: r.value = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? MAX_VAL - $urandom_range(0, 3)
                                      : MIN_VAL + $urandom_range(0, 3);
      1: return $signed(32'($urandom_range(0, 4095))) - 2048;
      2: return $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
      3: return '0;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [3:0] rand_op();
    // Mostly defined codes, with the unused ones mixed in now and then.
    if ($urandom_range(0, 15) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  // Offers one beat and holds it until the block takes it. The expectation
  // is queued at the accepting edge. Valid stays high into the next beat.
  task automatic send_beat(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(alu_predict(op, a, b));
    beats_sent++;
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Directed table: extremes, each operation and the named special cases.
  stim_row_t directed[] = '{
    '{OP_ADD, MAX_VAL, 32'sd1, 1, MAX_VAL, ST_OVF},
    '{OP_ADD, MIN_VAL, -32'sd1, 1, MIN_VAL, ST_OVF},
    '{OP_SUB, MIN_VAL, 32'sd1, 1, MIN_VAL, ST_OVF},
    '{OP_SUB, MAX_VAL, MIN_VAL, 1, MAX_VAL, ST_OVF},
    '{OP_MUL, 32'sd256, 32'sd256, 1, 32'sd256, ST_OK},
    '{OP_MUL, MAX_VAL, MAX_VAL, 1, MAX_VAL, ST_OVF},
    '{OP_MUL, MIN_VAL, MIN_VAL, 1, MAX_VAL, ST_OVF},
    '{OP_MUL, MIN_VAL, 32'sd256, 1, MIN_VAL, ST_OK},
    '{OP_MUL, 32'sd1, 32'sd128, 0, 0, 0},
    '{OP_MUL, -32'sd1, 32'sd128, 0, 0, 0},
    '{OP_DIV, 32'sd1000, 32'sd0, 1, 32'sd0, ST_DIVZ},
    '{OP_DIV, MIN_VAL, 32'sd0, 1, 32'sd0, ST_DIVZ},
    '{OP_DIV, MAX_VAL, 32'sd1, 1, MAX_VAL, ST_OVF},
    '{OP_DIV, MIN_VAL, -32'sd256, 1, MAX_VAL, ST_OVF},
    '{OP_DIV, 32'sd1, 32'sd512, 0, 0, 0},
    '{OP_DIV, -32'sd3, 32'sd1536, 0, 0, 0},
    '{OP_CMP, 32'sd5, 32'sd5, 1, 32'sd0, ST_OK},
    '{OP_MIN, MIN_VAL, MAX_VAL, 1, MIN_VAL, ST_OK},
    '{OP_MAX, MIN_VAL, MAX_VAL, 1, MAX_VAL, ST_OK},
    '{OP_INC, MAX_VAL, MIN_VAL, 1, MAX_VAL, ST_OVF},
    '{OP_DEC, MIN_VAL, MAX_VAL, 1, MIN_VAL, ST_OVF},
    '{OP_TOINT, MIN_VAL, 32'sd7, 1, -32'sd8388608, ST_OK},
    '{OP_TOINT, -32'sd1, 32'sd0, 1, -32'sd1, ST_OK},
    '{4'd15, 32'sd3, -32'sd3, 1, 32'sd0, ST_OK},
    '{4'd10, -32'sd3, 32'sd3, 1, 32'sd0, ST_OK}
  };

  // Result side: compare each accepted beat with the oldest expectation.
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: value %0d status %0d",
                   out_result_value, out_status);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_result_value !== exp_r.value || out_a_less !== exp_r.less ||
            out_a_equal !== exp_r.equal || out_a_greater !== exp_r.greater ||
            out_status !== exp_r.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected value %0d lt %b eq %b gt %b st %0d, got value %0d lt %b eq %b gt %b st %0d",
                     exp_r.value, exp_r.less, exp_r.equal, exp_r.greater, exp_r.status,
                     out_result_value, out_a_less, out_a_equal, out_a_greater, out_status);
        end
      end
    end
  end

  // Receiver stall pattern: phases of no stall, light and heavy random
  // stalling, plus one long hold requested by the stimulus thread.
  initial begin
    int mode, span;
    while (!stim_done) begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(5, 40);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
    @(posedge clk);
    out_stall <= 1'b0;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    stim_row_t row;
    alu_result_t known;
    int burst, drain;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      if (row.has_known) begin
        known = alu_predict(row.op, row.a, row.b);
        if (known.value !== row.known_value || known.status !== row.known_status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("table row %0d: expected value %0d status %0d, predicted %0d %0d",
                     i, row.known_value, row.known_status, known.value, known.status);
        end
      end
      send_beat(row.op, row.a, row.b);
    end

    // The sender stops here until every expected result has come back.
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);

    // Ask for a long receiver hold while beats keep coming, so the
    // pipeline fills up and the input stalls.
    long_hold = 1'b1;
    repeat (40) send_beat(rand_op(), rand_operand(), rand_operand());

    while (beats_sent < 1225) begin
      burst = $urandom_range(1, 30);
      repeat (burst) send_beat(rand_op(), rand_operand(), rand_operand());
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (pending_results.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 30) begin
      @(posedge clk);
      drain++;
    end
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
